>>> sv/srr_pkg.sv
// Shared types and constants for the selective-repeat receiver.
// No dependencies; imported by selective_repeat_receiver_unit.
package srr_pkg;

  localparam int PAYLOAD_W  = 160;  // 20 bytes
  localparam int GROUP_W    = 32;   // four bytes summed per cycle
  localparam int NUM_GROUPS = PAYLOAD_W / GROUP_W;
  localparam int GRP_CNT_W  = 3;
  localparam int ACC_W      = 13;   // holds sum of 20 signed bytes
  localparam int SEQ_OUT_W  = 4;
  localparam int CHK_OUT_W  = 5;

  localparam logic KIND_ACK  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SUM   = 5'b00010,
    S_CHECK = 5'b00100,
    S_ACK   = 5'b01000,
    S_DLV   = 5'b10000
  } srr_state_t;

  // Sum of four bytes, each read as signed 8-bit.
  function automatic logic signed [ACC_W-1:0] byte_sum4(input logic [GROUP_W-1:0] g);
    logic signed [ACC_W-1:0] s;
    s = '0;
    for (int i = 0; i < GROUP_W / 8; i++) begin
      s = s + ACC_W'(signed'(g[i*8 +: 8]));
    end
    return s;
  endfunction

endpackage

>>> sv/selective_repeat_receiver_unit.sv
// Selective-repeat ARQ receiver: checksum check, reorder buffer, in-order delivery.
// Depends on srr_pkg (types, constants, byte-sum helper).
//
//  channel | ports                               | dir | role
//  --------+-------------------------------------+-----+------------------------------
//  in_     | in_valid/in_ready + packet fields   | in  | one data packet per beat
//  out_    | out_valid/out_ready + result fields | out | ACK beat, then delivery beats
//
// A packet is checked in steps (accept, byte summing over five groups, compare),
// then its results leave, one per cycle while the output takes them: the ACK,
// then n deliveries; output stalls hold the FSM in place. The reorder store is a
// one-port-write, one-port-read memory with registered read; its read address
// follows the next expected slot so one delivery leaves per cycle. Reset (rst_n
// low, synchronous) clears flags and expected number, sets the ACK bit to one.
module selective_repeat_receiver_unit
  import srr_pkg::*;
#(
  parameter int SEQ_SPACE = 12
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   in_seq_num,
  input  logic signed [31:0]   in_ack_field,
  input  logic signed [31:0]   in_check_value,
  input  logic [63:0]          in_payload_low,
  input  logic [63:0]          in_payload_mid,
  input  logic [31:0]          in_payload_high,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_result_kind,
  output logic                 out_ack_header_bit,
  output logic [SEQ_OUT_W-1:0] out_acked_seq,
  output logic [CHK_OUT_W-1:0] out_ack_check,
  output logic [63:0]          out_payload_low,
  output logic [63:0]          out_payload_mid,
  output logic [31:0]          out_payload_high,
  output logic                 out_last_of_run
);

  localparam int IDX_W = (SEQ_SPACE > 1) ? $clog2(SEQ_SPACE) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEQ_SPACE - 1);

  srr_state_t state_r, state_nxt;

  logic [31:0]            seq_r, ack_r, chk_r;
  logic [PAYLOAD_W-1:0]   pl_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [GRP_CNT_W-1:0]   grp_r, grp_nxt;

  logic [SEQ_SPACE-1:0]   flags_r, flags_nxt;
  logic [IDX_W-1:0]       exp_r, exp_nxt, exp_inc;
  logic                   ackbit_r, ackbit_nxt;

  logic [PAYLOAD_W-1:0]   mem [SEQ_SPACE];
  logic [PAYLOAD_W-1:0]   rd_data_r;
  logic                   wr_en;

  logic                   ov_r;
  logic                   kind_r, hbit_r, last_r;
  logic [SEQ_OUT_W-1:0]   aseq_r;
  logic [CHK_OUT_W-1:0]   achk_r;
  logic [PAYLOAD_W-1:0]   opl_r;
  logic                   load;
  logic                   slot_free;

  logic [31:0]            sum;
  logic                   pkt_ok;
  logic [IDX_W-1:0]       seq_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !ov_r || out_ready;
  assign seq_idx   = seq_r[IDX_W-1:0];
  assign exp_inc   = (exp_r == LAST_IDX) ? '0 : exp_r + 1'b1;

  assign sum    = seq_r + ack_r + {{(32-ACC_W){acc_r[ACC_W-1]}}, acc_r};
  assign pkt_ok = (sum == chk_r) && (seq_r < 32'(SEQ_SPACE));

  always_comb begin
    state_nxt  = state_r;
    acc_nxt    = acc_r;
    grp_nxt    = grp_r;
    flags_nxt  = flags_r;
    exp_nxt    = exp_r;
    ackbit_nxt = ackbit_r;
    wr_en      = 1'b0;
    load       = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          acc_nxt   = '0;
          grp_nxt   = '0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        acc_nxt = acc_r + byte_sum4(pl_r[grp_r*GROUP_W +: GROUP_W]);
        grp_nxt = grp_r + 1'b1;
        if (grp_r == GRP_CNT_W'(NUM_GROUPS - 1)) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (pkt_ok) begin
          if (!flags_r[seq_idx]) begin
            wr_en              = 1'b1;
            flags_nxt[seq_idx] = 1'b1;
          end
          state_nxt = S_ACK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_ACK: begin
        if (slot_free) begin
          load       = 1'b1;
          ackbit_nxt = !ackbit_r;
          state_nxt  = flags_r[exp_r] ? S_DLV : S_IDLE;
        end
      end
      S_DLV: begin
        if (slot_free) begin
          load             = 1'b1;
          flags_nxt[exp_r] = 1'b0;
          exp_nxt          = exp_inc;
          state_nxt        = flags_r[exp_inc] ? S_DLV : S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      flags_r  <= '0;
      exp_r    <= '0;
      ackbit_r <= 1'b1;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      flags_r  <= flags_nxt;
      exp_r    <= exp_nxt;
      ackbit_r <= ackbit_nxt;
      if (load) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // Packet capture and checksum accumulator
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      seq_r <= in_seq_num;
      ack_r <= in_ack_field;
      chk_r <= in_check_value;
      pl_r  <= {in_payload_high, in_payload_mid, in_payload_low};
    end
    acc_r <= acc_nxt;
    grp_r <= grp_nxt;
  end

  // Reorder store; read address tracks next expected slot so data lands in time
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[seq_idx] <= pl_r;
    end
    rd_data_r <= mem[exp_nxt];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      if (state_r == S_ACK) begin
        kind_r <= KIND_ACK;
        hbit_r <= ackbit_r;
        aseq_r <= SEQ_OUT_W'(seq_idx);
        achk_r <= CHK_OUT_W'(seq_idx) + CHK_OUT_W'(ackbit_r);
        opl_r  <= '0;
        last_r <= !flags_r[exp_r];
      end else begin
        kind_r <= KIND_DATA;
        hbit_r <= 1'b0;
        aseq_r <= '0;
        achk_r <= '0;
        opl_r  <= rd_data_r;
        last_r <= !flags_r[exp_inc];
      end
    end
  end

  assign out_valid          = ov_r;
  assign out_result_kind    = kind_r;
  assign out_ack_header_bit = hbit_r;
  assign out_acked_seq      = aseq_r;
  assign out_ack_check      = achk_r;
  assign out_payload_low    = opl_r[63:0];
  assign out_payload_mid    = opl_r[127:64];
  assign out_payload_high   = opl_r[159:128];
  assign out_last_of_run    = last_r;

endmodule
